[rtl/core/fulf_pkg.sv]
// Shared constants, candidate type and compare helpers for the first unique letter finder.
`timescale 1ns / 1ps
package fulf_pkg;

  localparam int MAX_LEN       = 4096;
  localparam int ALPHABET_SIZE = 26;

  localparam int POS_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;

  // Reduction tree widths, four candidates per node.
  localparam int L1_N = (ALPHABET_SIZE + 3) / 4;
  localparam int L2_N = (L1_N + 3) / 4;
  localparam int L3_N = (L2_N + 3) / 4;

  localparam logic [7:0] CODE_A    = 8'd97;
  localparam logic [7:0] CODE_NONE = 8'd38;
  localparam logic [1:0] CNT_SAT   = 2'd2;
  localparam logic [1:0] CNT_ONE   = 2'd1;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] idx;
  } cand_t;

  // Left operand wins ties, so the lower letter index is kept.
  function automatic cand_t better2(input cand_t a, input cand_t b);
    if (a.ok && (!b.ok || a.pos <= b.pos)) begin
      return a;
    end
    return b;
  endfunction

  function automatic cand_t best4(input cand_t a, input cand_t b,
                                  input cand_t c, input cand_t d);
    return better2(better2(a, b), better2(c, d));
  endfunction

endpackage

[rtl/core/first_unique_letter_finder.sv]
// First unique letter finder: per-letter counters and a pipelined minimum search.
//
// Input channel (in_valid/in_ready): one letter index per transaction, is_last
// on the final letter of a string. Indexes at or above the alphabet size are
// ignored. Letters beyond MAX_LEN are dropped and flag overflow.
// Output channel (out_valid/out_ready): one transaction per string, carrying
// the code of the earliest letter seen exactly once (or '&'), found, overflow.
// Throughput: one letter per cycle while in_ready is high, strings back to
// back with no gap; the per-letter count and first-position update is one
// register stage. Result path: the snapshot taken with the last letter is
// registered in s0, then passes the s1, s2 and s3 levels of a registered 4-ary
// tree doing the 26-way earliest-position search, and the output register.
// Stall: results queue in the search pipeline (up to 5 pending). in_ready
// falls only once all of those stages hold results that are not yet taken.
// Reset (rst, synchronous): clears counters, flags and pipeline valid bits.
`timescale 1ns / 1ps
module first_unique_letter_finder
  import fulf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] letter,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] result_char,
  output logic       found,
  output logic       overflow
);

  // Per-string state
  logic [1:0]       cnt      [ALPHABET_SIZE];
  logic [1:0]       cnt_next [ALPHABET_SIZE];
  logic [POS_W-1:0] fpos      [ALPHABET_SIZE];
  logic [POS_W-1:0] fpos_next [ALPHABET_SIZE];
  logic [CNT_W-1:0] pos_ctr, pos_ctr_next;
  logic             ovf, ovf_next;

  // Search pipeline
  cand_t s0 [ALPHABET_SIZE];
  cand_t s1 [L1_N];
  cand_t s2 [L2_N];
  cand_t s3 [L3_N];
  cand_t p0 [L1_N*4];
  cand_t p1 [L2_N*4];
  cand_t p2 [L3_N*4];
  cand_t p3 [4];
  cand_t best;
  logic [3:0] v;
  logic [3:0] o;
  logic [4:0] rdy;

  logic             in_fire;
  logic [IDX_W-1:0] idx;
  logic             letter_ok;
  logic             full;
  logic             take;

  assign in_fire   = in_valid && in_ready;
  assign idx       = IDX_W'(letter);
  assign letter_ok = 32'(letter) < ALPHABET_SIZE;
  assign full      = pos_ctr >= CNT_W'(MAX_LEN);
  assign take      = in_fire && letter_ok && !full;

  always_comb begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      cnt_next[i]  = cnt[i];
      fpos_next[i] = fpos[i];
      if (take && idx == IDX_W'(i)) begin
        if (cnt[i] == 2'd0) begin
          fpos_next[i] = pos_ctr[POS_W-1:0];
        end
        if (cnt[i] < CNT_SAT) begin
          cnt_next[i] = cnt[i] + 2'd1;
        end
      end
    end
    pos_ctr_next = take ? pos_ctr + CNT_W'(1) : pos_ctr;
    ovf_next     = ovf || (in_fire && letter_ok && full);
  end

  always_ff @(posedge clk) begin
    fpos <= fpos_next;
    if (rst) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) cnt[i] <= 2'd0;
      pos_ctr <= '0;
      ovf     <= 1'b0;
    end else if (in_fire && is_last) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) cnt[i] <= 2'd0;
      pos_ctr <= '0;
      ovf     <= 1'b0;
    end else begin
      cnt     <= cnt_next;
      pos_ctr <= pos_ctr_next;
      ovf     <= ovf_next;
    end
  end

  // Backpressure ripples from the output register toward the input.
  always_comb begin
    rdy[4] = !out_valid || out_ready;
    rdy[3] = !v[3] || rdy[4];
    rdy[2] = !v[2] || rdy[3];
    rdy[1] = !v[1] || rdy[2];
    rdy[0] = !v[0] || rdy[1];
  end
  assign in_ready = rdy[0];

  // Pad each level to a multiple of four with empty candidates.
  genvar g;
  generate
    for (g = 0; g < L1_N*4; g++) begin : g_p0
      if (g < ALPHABET_SIZE) begin : g_real
        assign p0[g] = s0[g];
      end else begin : g_pad
        assign p0[g] = '0;
      end
    end
    for (g = 0; g < L2_N*4; g++) begin : g_p1
      if (g < L1_N) begin : g_real
        assign p1[g] = s1[g];
      end else begin : g_pad
        assign p1[g] = '0;
      end
    end
    for (g = 0; g < L3_N*4; g++) begin : g_p2
      if (g < L2_N) begin : g_real
        assign p2[g] = s2[g];
      end else begin : g_pad
        assign p2[g] = '0;
      end
    end
    for (g = 0; g < 4; g++) begin : g_p3
      if (g < L3_N) begin : g_real
        assign p3[g] = s3[g];
      end else begin : g_pad
        assign p3[g] = '0;
      end
    end
  endgenerate

  assign best = best4(p3[0], p3[1], p3[2], p3[3]);

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy[0] && in_fire && is_last) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        s0[i].ok  <= cnt_next[i] == CNT_ONE;
        s0[i].pos <= fpos_next[i];
        s0[i].idx <= IDX_W'(i);
      end
      o[0] <= ovf_next;
    end
    if (rdy[1]) begin
      for (int j = 0; j < L1_N; j++) begin
        s1[j] <= best4(p0[4*j], p0[4*j+1], p0[4*j+2], p0[4*j+3]);
      end
      o[1] <= o[0];
    end
    if (rdy[2]) begin
      for (int j = 0; j < L2_N; j++) begin
        s2[j] <= best4(p1[4*j], p1[4*j+1], p1[4*j+2], p1[4*j+3]);
      end
      o[2] <= o[1];
    end
    if (rdy[3]) begin
      for (int j = 0; j < L3_N; j++) begin
        s3[j] <= best4(p2[4*j], p2[4*j+1], p2[4*j+2], p2[4*j+3]);
      end
      o[3] <= o[2];
    end
    if (rdy[4]) begin
      result_char <= best.ok ? 8'(9'(CODE_A) + 9'(best.idx)) : CODE_NONE;
      found       <= best.ok;
      overflow    <= o[3];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[0]) v[0] <= in_fire && is_last;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) out_valid <= v[3];
    end
  end

  a_found_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> result_char == CODE_NONE)
    else $error("no unique letter but result code is not the none code");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos_ctr <= CNT_W'(MAX_LEN))
    else $error("position counter passed the length limit");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> pos_ctr == CNT_W'(MAX_LEN))
    else $error("overflow flagged before the string filled");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_last |=> pos_ctr == '0 && !ovf)
    else $error("string state not cleared after last letter");

endmodule

[bench/tb_first_unique_letter_finder.sv]
// Self-checking testbench for first_unique_letter_finder with a scoreboard class.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] code;
  logic       hit;
  logic       ovf;
} letter_answer_t;

class first_unique_tracker;
  logic [1:0]                  seen_cnt[fulf_pkg::ALPHABET_SIZE];
  logic [fulf_pkg::POS_W-1:0]  first_at[fulf_pkg::ALPHABET_SIZE];
  int unsigned                 taken;
  bit                          overflowed;
  letter_answer_t              answers_due[$];
  int                          errors;
  int                          strings_done;
  int                          compared;
  int                          overflow_answers;

  function new();
    clear_string();
    errors = 0;
    strings_done = 0;
    compared = 0;
    overflow_answers = 0;
  endfunction

  function void clear_string();
    foreach (seen_cnt[k]) begin
      seen_cnt[k] = '0;
      first_at[k] = '0;
    end
    taken = 0;
    overflowed = 0;
  endfunction

  function int pending();
    return answers_due.size();
  endfunction

  // Called for every accepted input transaction.
  function void take_letter(logic [4:0] l, logic last);
    letter_answer_t a;
    bit have;
    int best;
    if (l < fulf_pkg::ALPHABET_SIZE) begin
      if (taken >= fulf_pkg::MAX_LEN) begin
        overflowed = 1;
      end else begin
        if (seen_cnt[l] == 2'd0) first_at[l] = taken[fulf_pkg::POS_W-1:0];
        if (seen_cnt[l] < fulf_pkg::CNT_SAT) seen_cnt[l] = seen_cnt[l] + 2'd1;
        taken++;
      end
    end
    if (!last) return;
    have = 0;
    best = 0;
    for (int k = 0; k < fulf_pkg::ALPHABET_SIZE; k++) begin
      if (seen_cnt[k] == fulf_pkg::CNT_ONE && (!have || first_at[k] < first_at[best])) begin
        have = 1;
        best = k;
      end
    end
    a.code = have ? fulf_pkg::CODE_A + 8'(best) : fulf_pkg::CODE_NONE;
    a.hit  = have;
    a.ovf  = overflowed;
    answers_due.push_back(a);
    strings_done++;
    clear_string();
  endfunction

  task report_mismatch(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Called for every accepted output transaction.
  task check_answer(logic [7:0] code, logic hit, logic ovf);
    letter_answer_t a;
    if (answers_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result char=%0d found=%0b overflow=%0b",
                                code, hit, ovf));
      return;
    end
    a = answers_due.pop_front();
    compared++;
    if (ovf) overflow_answers++;
    if (code !== a.code)
      report_mismatch($sformatf("result_char got %0d want %0d", code, a.code));
    if (hit !== a.hit)
      report_mismatch($sformatf("found got %0b want %0b", hit, a.hit));
    if (ovf !== a.ovf)
      report_mismatch($sformatf("overflow got %0b want %0b", ovf, a.ovf));
  endtask
endclass

module tb_first_unique_letter_finder;
  import fulf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [4:0] letter = '0;
  logic       is_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] result_char;
  logic       found;
  logic       overflow;

  first_unique_tracker board = new();

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  in_range_sent = 0;
  int  letters_sent = 0;
  bit  holding = 0;
  event hold_go;

  first_unique_letter_finder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .letter(letter), .is_last(is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_char(result_char), .found(found), .overflow(overflow)
  );

  always #10 clk = ~clk;

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  always begin
    @(hold_go);
    @(posedge clk);
    holding = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 0;
  end

  always @(negedge clk) begin
    if (holding) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_answer(result_char, found, overflow);
  end

  // Entered and left at a falling edge.
  task automatic send_letter(input logic [4:0] l, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    letter   <= l;
    is_last  <= last;
    do @(posedge clk); while (!in_ready);
    board.take_letter(l, last);
    letters_sent++;
    if (l < ALPHABET_SIZE) in_range_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_string(input int len, input int alpha, input int junk_pct);
    logic [4:0] l;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < junk_pct) l = 5'($urandom_range(31, ALPHABET_SIZE));
      else l = 5'($urandom_range(alpha - 1));
      send_letter(l, i == len - 1);
    end
  endtask

  // MAX_LEN counted letters with a lone 'z' at the last counted slot.
  task automatic send_full_string(input bit overrun);
    for (int i = 0; i < MAX_LEN - 1; i++) send_letter(5'($urandom_range(24)), 1'b0);
    send_letter(5'd25, 1'b0);
    if (overrun) begin
      send_letter(5'($urandom_range(31, ALPHABET_SIZE)), 1'b0);
      send_letter(5'($urandom_range(24)), 1'b0);
      send_letter(5'd25, 1'b1);
    end else begin
      send_letter(5'($urandom_range(31, ALPHABET_SIZE)), 1'b1);
    end
  endtask

  task automatic run_mix(input int in_pct, input int out_pct, input int quota);
    int stop_at;
    int len;
    send_idle_pct = in_pct;
    stall_pct = out_pct;
    stop_at = in_range_sent + quota;
    while (in_range_sent < stop_at) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
      send_random_string(len, $urandom_range(ALPHABET_SIZE, 1), ($urandom_range(3) == 0) ? 15 : 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single letters, including an index past the alphabet with nothing before it
    send_letter(5'd0, 1'b1);
    send_letter(5'd25, 1'b1);
    send_letter(5'd31, 1'b1);
    // nothing unique
    send_letter(5'd1, 1'b0);
    send_letter(5'd1, 1'b1);
    // "abcab" -> c
    send_letter(5'd0, 1'b0);
    send_letter(5'd1, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd0, 1'b0);
    send_letter(5'd1, 1'b1);
    // ignored indexes mixed in
    send_letter(5'd26, 1'b0);
    send_letter(5'd3, 1'b0);
    send_letter(5'd30, 1'b0);
    send_letter(5'd3, 1'b0);
    send_letter(5'd4, 1'b1);
    // ignored index carrying the end mark
    send_letter(5'd7, 1'b0);
    send_letter(5'd29, 1'b1);
    // earliest unique wins over a later one
    send_letter(5'd25, 1'b0);
    send_letter(5'd24, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd16, 1'b0);
    send_letter(5'd24, 1'b0);
    send_letter(5'd15, 1'b1);

    run_mix(0, 0, 400);
    send_full_string(1'b0);
    send_full_string(1'b1);
    run_mix(62, 0, 400);
    run_mix(0, 62, 400);
    run_mix(8, 8, 400);

    // fill the result pipeline while the receiver is held off
    send_idle_pct = 0;
    stall_pct = 0;
    -> hold_go;
    for (int s = 0; s < 40; s++) send_random_string($urandom_range(2, 1), ALPHABET_SIZE, 0);
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d letters in %0d strings, incl. two at the length limit",
             letters_sent, board.strings_done);
    $display("%0d results compared, %0d flagged overflow, %0d mismatches",
             board.compared, board.overflow_answers, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
